>>> src/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg: shared constants and types of the sliding-window mode filter
// Field widths, reset values and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package swm_pkg;

   localparam int WINDOW_MAX_DEF = 1024;
   localparam int VALUE_BITS_DEF = 8;

   localparam int SAMPLE_BITS   = 8;
   localparam int LEN_BITS      = 11;
   localparam int COUNT_BITS    = 11;
   localparam int RSP_DATA_BITS = 24;

   localparam logic [LEN_BITS-1:0]   LEN_RESET = LEN_BITS'(1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // one-cycle commands from the controller
   typedef struct packed {
      logic accept;     // input transfer: latch sample, apply restart
      logic win_step;   // read oldest slot, write new sample, advance pointer
      logic rd_old;     // read count of the outgoing sample
      logic dec;        // write decremented count, read count of new sample
      logic rd_new;     // read count of new sample
      logic inc;        // write incremented count, update mode
      logic scan_step;  // read next count of the rescan
      logic out_load;   // load result into the output register
   } swm_cmd_type;

   typedef struct packed {
      logic full;       // window already full (valid while win_step)
      logic emit;       // this sample produces a result
      logic same;       // outgoing sample equals the new one
      logic search;     // mode left the window, rescan needed
      logic scan_last;  // rescan is at the last value
      logic out_free;   // output register can take a result
   } swm_stat_type;

endpackage

>>> src/swm_ctrl.sv
// ----------------------------------------------------------------------------
// swm_ctrl: sequencer of the sliding-window mode filter
// Steps one sample through the window update, the count updates, an
// optional rescan of all counts and, for a result, the load of the output register.
// ----------------------------------------------------------------------------
module swm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  swm_pkg::swm_stat_type stat,
   output swm_pkg::swm_cmd_type  cmd
);
   import swm_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_WIN    = 4'd1;
   localparam logic [3:0] S_RD_OLD = 4'd2;
   localparam logic [3:0] S_DEC    = 4'd3;
   localparam logic [3:0] S_RD_NEW = 4'd4;
   localparam logic [3:0] S_INC    = 4'd5;
   localparam logic [3:0] S_SCAN   = 4'd6;
   localparam logic [3:0] S_DRAIN  = 4'd7;
   localparam logic [3:0] S_OUT    = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_tready = (state_ff == S_IDLE) && !reset;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.accept = 1'b1;
               state_in   = S_WIN;
            end
         end
         S_WIN: begin
            cmd.win_step = 1'b1;
            state_in     = stat.full ? S_RD_OLD : S_RD_NEW;
         end
         S_RD_OLD: begin
            // same value leaving and entering: counts and mode stay
            if (stat.same) begin
               state_in = S_OUT;
            end else begin
               cmd.rd_old = 1'b1;
               state_in   = S_DEC;
            end
         end
         S_DEC: begin
            cmd.dec  = 1'b1;
            state_in = S_INC;
         end
         S_RD_NEW: begin
            cmd.rd_new = 1'b1;
            state_in   = S_INC;
         end
         S_INC: begin
            cmd.inc = 1'b1;
            if (stat.search) begin
               state_in = S_SCAN;
            end else if (stat.emit) begin
               state_in = S_OUT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> src/swm_dpath.sv
// ----------------------------------------------------------------------------
// swm_dpath: datapath of the sliding-window mode filter
// Delay-line memory, count memory with per-value valid bits, window
// bookkeeping, running highest count and mode, and the output register.
// ----------------------------------------------------------------------------
module swm_dpath #(
   parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF,
   parameter int VALUE_BITS = swm_pkg::VALUE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [swm_pkg::LEN_BITS-1:0]       csr_wdata,
   input  logic [swm_pkg::SAMPLE_BITS-1:0]    req_tdata,
   input  logic                               req_tuser,
   input  swm_pkg::swm_cmd_type               cmd,
   output swm_pkg::swm_stat_type              stat,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [swm_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);
   import swm_pkg::*;

   localparam int NUM_VALUES = 1 << VALUE_BITS;
   localparam int PTR_BITS   = $clog2(WINDOW_MAX);
   localparam int LEN_MAX    = (WINDOW_MAX < (1 << LEN_BITS) - 1) ?
                               WINDOW_MAX : (1 << LEN_BITS) - 1;

   logic [VALUE_BITS-1:0]    win_mem [WINDOW_MAX];
   logic [COUNT_BITS-1:0]    cnt_mem [NUM_VALUES];

   logic [LEN_BITS-1:0]      len_ff,    len_in;
   logic [LEN_BITS-1:0]      fill_ff,   fill_in;
   logic [PTR_BITS-1:0]      wptr_ff,   wptr_in;
   logic [COUNT_BITS-1:0]    high_ff,   high_in;
   logic [VALUE_BITS-1:0]    mode_ff,   mode_in;
   logic [VALUE_BITS-1:0]    sample_ff, sample_in;
   logic                     emit_ff,   emit_in;
   logic                     search_ff, search_in;
   logic [VALUE_BITS-1:0]    scan_idx_ff,  scan_idx_in;
   logic [VALUE_BITS-1:0]    scan_cidx_ff, scan_cidx_in;
   logic                     scan_pv_ff,   scan_pv_in;
   logic [NUM_VALUES-1:0]    cvalid_ff, cvalid_in;
   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_BITS-1:0] rsp_tdata_ff,  rsp_tdata_in;

   logic [VALUE_BITS-1:0]    old_ff;
   logic [COUNT_BITS-1:0]    cnt_rd_ff;
   logic                     cnt_vld_ff;

   logic [LEN_BITS-1:0]      eff_len;
   logic                     full_now;
   logic                     clr;
   logic [COUNT_BITS-1:0]    cnt_q;
   logic [COUNT_BITS-1:0]    inc_val;
   logic                     cnt_re;
   logic                     cnt_we;
   logic [VALUE_BITS-1:0]    cnt_ra;
   logic [VALUE_BITS-1:0]    cnt_wa;
   logic [COUNT_BITS-1:0]    cnt_wd;
   logic                     out_free;

   // window length: zero means one, saturate at the delay-line depth
   always_comb begin
      eff_len = len_ff;
      if (len_ff == '0) begin
         eff_len = LEN_BITS'(1);
      end else if (32'(len_ff) > LEN_MAX) begin
         eff_len = LEN_BITS'(LEN_MAX);
      end
   end

   assign full_now = (fill_ff >= eff_len);
   assign clr      = csr_we || (cmd.accept && req_tuser);
   assign cnt_q    = cnt_vld_ff ? cnt_rd_ff : '0;
   assign inc_val  = (cnt_q != COUNT_MAX) ? cnt_q + COUNT_BITS'(1) : cnt_q;
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   // count memory port selection
   always_comb begin
      cnt_re = cmd.rd_old || cmd.dec || cmd.rd_new || cmd.scan_step;
      if (cmd.rd_old) begin
         cnt_ra = old_ff;
      end else if (cmd.scan_step) begin
         cnt_ra = scan_idx_ff;
      end else begin
         cnt_ra = sample_ff;
      end
      cnt_we = (cmd.dec && (cnt_q != '0)) || (cmd.inc && (cnt_q != COUNT_MAX));
      cnt_wa = cmd.dec ? old_ff : sample_ff;
      cnt_wd = cmd.dec ? cnt_q - COUNT_BITS'(1) : inc_val;
   end

   always_comb begin
      len_in        = len_ff;
      fill_in       = fill_ff;
      wptr_in       = wptr_ff;
      high_in       = high_ff;
      mode_in       = mode_ff;
      sample_in     = sample_ff;
      emit_in       = emit_ff;
      search_in     = search_ff;
      scan_idx_in   = scan_idx_ff;
      scan_cidx_in  = scan_cidx_ff;
      scan_pv_in    = cmd.scan_step;
      cvalid_in     = cvalid_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;

      if (csr_we) begin
         len_in = csr_wdata;
      end
      if (cmd.accept) begin
         sample_in = VALUE_BITS'(req_tdata);
      end
      if (clr) begin
         fill_in   = '0;
         wptr_in   = '0;
         high_in   = '0;
         mode_in   = '0;
         cvalid_in = '0;
      end

      if (cmd.win_step) begin
         emit_in   = full_now || ((fill_ff + LEN_BITS'(1)) == eff_len);
         search_in = 1'b0;
         if (!full_now) begin
            fill_in = fill_ff + LEN_BITS'(1);
         end
         if ((32'(wptr_ff) + 32'd1) >= 32'(eff_len)) begin
            wptr_in = '0;
         end else begin
            wptr_in = wptr_ff + PTR_BITS'(1);
         end
      end

      if (cmd.dec) begin
         search_in = (old_ff == mode_ff);
      end

      if (cnt_we) begin
         cvalid_in[cnt_wa] = 1'b1;
      end

      if (cmd.inc) begin
         if (search_ff) begin
            // mode dropped out: rebuild it from scratch
            high_in     = '0;
            mode_in     = '0;
            scan_idx_in = '0;
         end else if (inc_val > high_ff) begin
            high_in = inc_val;
            mode_in = sample_ff;
         end else if ((inc_val == high_ff) && (sample_ff < mode_ff)) begin
            mode_in = sample_ff;
         end
      end

      if (cmd.scan_step) begin
         scan_cidx_in = scan_idx_ff;
         scan_idx_in  = scan_idx_ff + VALUE_BITS'(1);
      end
      // strictly greater keeps the smallest value on ties
      if (scan_pv_ff && (cnt_q > high_ff)) begin
         high_in = cnt_q;
         mode_in = scan_cidx_ff;
      end

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {(RSP_DATA_BITS - SAMPLE_BITS - COUNT_BITS)'(0),
                          high_ff, SAMPLE_BITS'(mode_ff)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= LEN_RESET;
         fill_ff       <= '0;
         wptr_ff       <= '0;
         high_ff       <= '0;
         mode_ff       <= '0;
         emit_ff       <= 1'b0;
         search_ff     <= 1'b0;
         scan_idx_ff   <= '0;
         scan_pv_ff    <= 1'b0;
         cvalid_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         len_ff        <= len_in;
         fill_ff       <= fill_in;
         wptr_ff       <= wptr_in;
         high_ff       <= high_in;
         mode_ff       <= mode_in;
         emit_ff       <= emit_in;
         search_ff     <= search_in;
         scan_idx_ff   <= scan_idx_in;
         scan_pv_ff    <= scan_pv_in;
         cvalid_ff     <= cvalid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      scan_cidx_ff <= scan_cidx_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // delay line: read the oldest slot before it is overwritten
   always_ff @(posedge clock) begin
      if (cmd.win_step) begin
         old_ff           <= win_mem[wptr_ff];
         win_mem[wptr_ff] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      if (cnt_re) begin
         cnt_rd_ff  <= cnt_mem[cnt_ra];
         cnt_vld_ff <= cvalid_ff[cnt_ra];
      end
   end

   always_comb begin
      stat.full      = full_now;
      stat.emit      = emit_ff;
      stat.same      = (old_ff == sample_ff);
      stat.search    = search_ff;
      stat.scan_last = (scan_idx_ff == '1);
      stat.out_free  = out_free;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

>>> src/sliding_window_mode.sv
// ----------------------------------------------------------------------------
// sliding_window_mode: running mode of the last window_len samples
//
//   channel  ports         payload
//   input    req_t*        tdata[7:0] sample, tuser restart
//   result   rsp_t*        tdata[7:0] mode_value, tdata[18:8] mode_count
//   config   csr_we/wdata  wdata[10:0] window_len
//
// A sample passes the window step, a read and increment of its count; once
// the window is full, the outgoing sample's count is read and decremented
// first, and no count changes when it equals the new one; when it was the
// mode, counts are rescanned one value per cycle via the count memory port.
// Reset and every window_len write or restart clear the counts at once.
// A result waiting in the output register stalls only the next result.
// ----------------------------------------------------------------------------
module sliding_window_mode #(
   parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF,
   parameter int VALUE_BITS = swm_pkg::VALUE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [swm_pkg::SAMPLE_BITS-1:0]    req_tdata,   // [7:0] sample
   input  logic                               req_tuser,   // [0] restart
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [swm_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,   // [7:0] mode_value,
                                                           // [18:8] mode_count
   input  logic                               csr_we,
   input  logic [swm_pkg::LEN_BITS-1:0]       csr_wdata    // window_len
);
   import swm_pkg::*;

   swm_cmd_type  cmd;
   swm_stat_type stat;

   swm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   swm_dpath #(
      .WINDOW_MAX (WINDOW_MAX),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> src/swm_checker.sv
// ----------------------------------------------------------------------------
// swm_checker: port-level checks of the sliding-window mode filter
// Watches the top-level handshakes and result fields over time.
// ----------------------------------------------------------------------------
module swm_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [swm_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);
   import swm_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a reported mode occurs at least once and padding stays zero
   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[18:8] != '0) && (rsp_tdata[23:19] == '0))
      else $error("bad mode count or padding");

   // one sample at a time: no input transfer back to back
   a_req_seq: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while busy");

   // a new result only appears while a sample is being worked on
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared while idle");

endmodule

bind sliding_window_mode swm_checker u_swm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
